// ===== src/array_list_with_binary_search_top_assert.svh =====
// Assertion macros for the array list with binary search.
`ifndef ARRAY_LIST_WITH_BINARY_SEARCH_TOP_ASSERT_SVH
`define ARRAY_LIST_WITH_BINARY_SEARCH_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is low.
`define ABSL_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ABSL_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ABSL_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define ABSL_ASSERT_NXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== src/absl_pkg.sv =====
// Shared types and codes for the array list with binary search.
`timescale 1ns / 1ps

package absl_pkg;

    localparam int POS_W   = 10;
    localparam int DATA_W  = 32;
    localparam int LEN_W   = 11;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND  = 3'd0,
        CMD_INSERT  = 3'd1,
        CMD_DEL_POS = 3'd2,
        CMD_DEL_VAL = 3'd3,
        CMD_MOD_POS = 3'd4,
        CMD_MOD_VAL = 3'd5,
        CMD_FIND    = 3'd6
    } absl_cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_BADPOS   = 3'd4
    } absl_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POS_WAIT,
        S_INS_SHIFT,
        S_INS_PUT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DEL_START,
        S_DEL_SHIFT,
        S_DONE
    } absl_state_t;

    typedef struct packed {
        absl_cmd_t          cmd;
        logic [POS_W-1:0]   position;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] new_value;
    } absl_req_t;

    typedef struct packed {
        absl_status_t       status;
        logic [POS_W-1:0]   found_index;
        logic signed [DATA_W-1:0] old_value;
        logic [LEN_W-1:0]   list_length;
    } absl_res_t;

endpackage

// ===== src/absl_engine.sv =====
// Command sequencer and entry memory: decode, binary search, shift up and down.
`timescale 1ns / 1ps

module absl_engine import absl_pkg::*; #(
    parameter int CAPACITY = 1024
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      req_valid,
    output logic      req_ready,
    input  absl_req_t req,
    output logic      res_valid,
    input  logic      res_take,
    output absl_res_t res
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CW     = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    logic signed [DATA_W-1:0] mem [CAPACITY];
    logic signed [DATA_W-1:0] rd_data_reg;

    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic                     mem_re;
    logic [ADDR_W-1:0]        mem_raddr;

    absl_state_t   state_reg, state_next;
    absl_req_t     req_reg, req_next;
    absl_status_t  status_reg, status_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic signed [DATA_W-1:0] old_reg, old_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hix_reg, hix_next;     // search window is [lo, hix)

    // Shared conditions
    logic [CW-1:0]    cnt_ext, pos_ext, ptr_ext, ptr_inc_ext;
    logic             is_full, is_empty, del_more;
    logic [CNT_W-1:0] mid;
    logic             key_match, key_less;
    logic [CNT_W-1:0] srch_lo_n, srch_hix_n;
    logic             srch_more;

    assign cnt_ext     = CW'(count_reg);
    assign pos_ext     = CW'(req_reg.position);
    assign ptr_ext     = CW'(ptr_reg);
    assign ptr_inc_ext = ptr_ext + CW'(1);
    assign is_full     = (count_reg == CNT_W'(CAPACITY));
    assign is_empty    = (count_reg == '0);
    assign del_more    = (ptr_inc_ext < cnt_ext);
    assign mid         = lo_reg + ((hix_reg - lo_reg - CNT_W'(1)) >> 1);
    assign key_match   = (rd_data_reg == req_reg.value);
    assign key_less    = (rd_data_reg < req_reg.value);
    assign srch_lo_n   = key_less ? (CNT_W'(ptr_reg) + CNT_W'(1)) : lo_reg;
    assign srch_hix_n  = key_less ? hix_reg : CNT_W'(ptr_reg);
    assign srch_more   = (srch_lo_n < srch_hix_n);

    // Entry memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        status_reg <= status_next;
        idx_reg    <= idx_next;
        ptr_reg    <= ptr_next;
        old_reg    <= old_next;
        lo_reg     <= lo_next;
        hix_reg    <= hix_next;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (req_reg.cmd)
                    CMD_INSERT: begin
                        if (!is_full && pos_ext < cnt_ext) begin
                            state_next = S_INS_SHIFT;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                    CMD_DEL_POS, CMD_MOD_POS: begin
                        if (!is_empty && pos_ext < cnt_ext) begin
                            state_next = S_POS_WAIT;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                    CMD_DEL_VAL, CMD_MOD_VAL, CMD_FIND: begin
                        state_next = is_empty ? S_DONE : S_SRCH_RD;
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_POS_WAIT: begin
                state_next = (req_reg.cmd == CMD_DEL_POS) ? S_DEL_START : S_DONE;
            end
            S_INS_SHIFT: begin
                if (ptr_ext == pos_ext) begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT: begin
                state_next = S_DONE;
            end
            S_SRCH_RD: begin
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (key_match) begin
                    state_next = (req_reg.cmd == CMD_DEL_VAL) ? S_DEL_START : S_DONE;
                end else if (srch_more) begin
                    state_next = S_SRCH_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DEL_START, S_DEL_SHIFT: begin
                if (!del_more) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_DEL_SHIFT;
                end
            end
            S_DONE: begin
                if (res_take) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb begin
        req_next    = req_reg;
        status_next = status_reg;
        idx_next    = idx_reg;
        ptr_next    = ptr_reg;
        old_next    = old_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hix_next    = hix_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    req_next    = req;
                    status_next = ST_OK;
                    idx_next    = '0;
                    old_next    = '0;
                end
            end
            S_DECODE: begin
                unique case (req_reg.cmd)
                    CMD_APPEND: begin
                        if (is_full) begin
                            status_next = ST_FULL;
                        end else begin
                            mem_we     = 1'b1;
                            mem_waddr  = ADDR_W'(count_reg);
                            mem_wdata  = req_reg.value;
                            idx_next   = ADDR_W'(count_reg);
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    CMD_INSERT: begin
                        if (is_full) begin
                            status_next = ST_FULL;
                        end else if (pos_ext > cnt_ext) begin
                            status_next = ST_BADPOS;
                        end else if (pos_ext == cnt_ext) begin
                            // insert at the end: no shift
                            mem_we     = 1'b1;
                            mem_waddr  = ADDR_W'(pos_ext);
                            mem_wdata  = req_reg.value;
                            idx_next   = ADDR_W'(pos_ext);
                            count_next = count_reg + CNT_W'(1);
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = ADDR_W'(count_reg - CNT_W'(1));
                            ptr_next  = ADDR_W'(count_reg - CNT_W'(1));
                        end
                    end
                    CMD_DEL_POS, CMD_MOD_POS: begin
                        if (is_empty) begin
                            status_next = ST_EMPTY;
                        end else if (pos_ext >= cnt_ext) begin
                            status_next = ST_BADPOS;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = ADDR_W'(pos_ext);
                            idx_next  = ADDR_W'(pos_ext);
                        end
                    end
                    CMD_DEL_VAL, CMD_MOD_VAL, CMD_FIND: begin
                        if (is_empty) begin
                            status_next = (req_reg.cmd == CMD_FIND) ? ST_NOTFOUND : ST_EMPTY;
                        end else begin
                            lo_next  = '0;
                            hix_next = count_reg;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_POS_WAIT: begin
                old_next = rd_data_reg;
                ptr_next = idx_reg;
                if (req_reg.cmd == CMD_MOD_POS) begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg;
                    mem_wdata = req_reg.new_value;
                end
            end
            S_INS_SHIFT: begin
                // data read at ptr moves up one; next read one below
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(ptr_inc_ext);
                mem_wdata = rd_data_reg;
                if (ptr_ext != pos_ext) begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg - ADDR_W'(1);
                    ptr_next  = ptr_reg - ADDR_W'(1);
                end
            end
            S_INS_PUT: begin
                mem_we     = 1'b1;
                mem_waddr  = ADDR_W'(pos_ext);
                mem_wdata  = req_reg.value;
                idx_next   = ADDR_W'(pos_ext);
                count_next = count_reg + CNT_W'(1);
            end
            S_SRCH_RD: begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(mid);
                ptr_next  = ADDR_W'(mid);
            end
            S_SRCH_CMP: begin
                if (key_match) begin
                    idx_next = ptr_reg;
                    if (req_reg.cmd != CMD_FIND) begin
                        old_next = rd_data_reg;
                    end
                    if (req_reg.cmd == CMD_MOD_VAL) begin
                        mem_we    = 1'b1;
                        mem_waddr = ptr_reg;
                        mem_wdata = req_reg.new_value;
                    end
                end else begin
                    lo_next  = srch_lo_n;
                    hix_next = srch_hix_n;
                    if (!srch_more) begin
                        status_next = ST_NOTFOUND;
                    end
                end
            end
            S_DEL_START, S_DEL_SHIFT: begin
                if (state_reg == S_DEL_SHIFT) begin
                    mem_we    = 1'b1;
                    mem_waddr = ptr_reg - ADDR_W'(1);
                    mem_wdata = rd_data_reg;
                end
                if (del_more) begin
                    mem_re    = 1'b1;
                    mem_raddr = ADDR_W'(ptr_inc_ext);
                    ptr_next  = ADDR_W'(ptr_inc_ext);
                end else begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign req_ready       = (state_reg == S_IDLE);
    assign res_valid       = (state_reg == S_DONE);
    assign res.status      = status_reg;
    assign res.found_index = POS_W'(CW'(idx_reg));
    assign res.old_value   = old_reg;
    assign res.list_length = LEN_W'(cnt_ext);

endmodule

// ===== src/array_list_with_binary_search_top.sv =====
// Top level of the array list with binary search: stream ports and result register.
`timescale 1ns / 1ps

// Packed list of signed 32-bit words held in one single-port-read,
// single-port-write memory of CAPACITY entries, with binary search
// lookups that assume ascending contents. One request is in work at a
// time; its result sits in an output register so the next request can
// be taken while that result waits. Request time is set by the one
// memory read per cycle: insert moves the entries from the position
// upward up by one, one entry at a time, and delete by position moves
// the entries above the position down the same way; value commands
// run search probes, with at most log2(CAPACITY) + 1 probes, and
// delete by value then moves the entries above the found index down.

`include "array_list_with_binary_search_top_assert.svh"

module array_list_with_binary_search_top import absl_pkg::*; #(
    parameter int CAPACITY = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // position[9:0], value[41:10], new_value[73:42], zeros
    input  logic [2:0]  s_tuser,   // cmd[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // found_index[9:0], old_value[41:10], list_length[52:42]
    output logic [2:0]  m_tuser    // status[2:0]
);

    absl_req_t req;
    absl_res_t eng_res;
    absl_res_t m_res_reg;
    logic      m_tvalid_reg;
    logic      eng_valid;
    logic      res_take;

    assign req.cmd       = absl_cmd_t'(s_tuser);
    assign req.position  = s_tdata[9:0];
    assign req.value     = s_tdata[41:10];
    assign req.new_value = s_tdata[73:42];

    // result slot frees when empty or being drained
    assign res_take = !m_tvalid_reg || m_tready;

    absl_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (eng_valid),
        .res_take  (res_take),
        .res       (eng_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_take) begin
            m_tvalid_reg <= eng_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take && eng_valid) begin
            m_res_reg <= eng_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {3'b000, m_res_reg.list_length, m_res_reg.old_value,
                       m_res_reg.found_index};

    // one request in work at a time
    `ABSL_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request taken while busy")
    `ABSL_ASSERT_IMP(a_len_in_range, aclk, aresetn, m_tvalid_reg, m_res_reg.list_length <= CAPACITY, "length beyond capacity")
    `ABSL_ASSERT_IMP(a_fail_index_zero, aclk, aresetn, m_tvalid_reg && (m_res_reg.status != ST_OK), m_res_reg.found_index == '0, "index set on failed request")

endmodule
